[rtl/rtsi_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rtsi_pkg;

   localparam int WORD_BITS  = 32;
   localparam int CNT_BITS   = $clog2(WORD_BITS + 1);
   localparam int SHIFT_BITS = $clog2(WORD_BITS);

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_BAD_DEN  = 2'd1,
      ST_INEXACT  = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_GCD,
      S_NUM_LD,
      S_NUM_DIV,
      S_DEN_LD,
      S_DEN_DIV,
      S_SCL_LD,
      S_SCL_DIV,
      S_MUL,
      S_FIN,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      DIV_NUM,
      DIV_DEN,
      DIV_SCL
   } div_sel_type;

   typedef struct packed {
      logic        load;
      logic        gcd_step;
      logic        div_load;
      div_sel_type div_sel;
      logic        div_step;
      logic        num_save;
      logic        den_save;
      logic        mul;
      logic        fin;
   } cmd_type;

   typedef struct packed {
      logic bad_den;
      logic gcd_done;
      logic div_done;
   } sts_type;

endpackage

`default_nettype wire

[rtl/rtsi_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module rtsi_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rtsi_pkg::cmd_type      cmd,
   input  wire rtsi_pkg::sts_type sts
);

   rtsi_pkg::state_type state_ff;
   rtsi_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rtsi_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rtsi_pkg::S_IDLE: begin
            if (req_valid) state_in = rtsi_pkg::S_CHECK;
         end
         rtsi_pkg::S_CHECK: begin
            state_in = sts.bad_den ? rtsi_pkg::S_FIN : rtsi_pkg::S_GCD;
         end
         rtsi_pkg::S_GCD: begin
            if (sts.gcd_done) state_in = rtsi_pkg::S_NUM_LD;
         end
         rtsi_pkg::S_NUM_LD:  state_in = rtsi_pkg::S_NUM_DIV;
         rtsi_pkg::S_NUM_DIV: begin
            if (sts.div_done) state_in = rtsi_pkg::S_DEN_LD;
         end
         rtsi_pkg::S_DEN_LD:  state_in = rtsi_pkg::S_DEN_DIV;
         rtsi_pkg::S_DEN_DIV: begin
            if (sts.div_done) state_in = rtsi_pkg::S_SCL_LD;
         end
         rtsi_pkg::S_SCL_LD:  state_in = rtsi_pkg::S_SCL_DIV;
         rtsi_pkg::S_SCL_DIV: begin
            if (sts.div_done) state_in = rtsi_pkg::S_MUL;
         end
         rtsi_pkg::S_MUL:     state_in = rtsi_pkg::S_FIN;
         rtsi_pkg::S_FIN:     state_in = rtsi_pkg::S_DONE;
         rtsi_pkg::S_DONE: begin
            if (rsp_ready) state_in = rtsi_pkg::S_IDLE;
         end
         default:             state_in = rtsi_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         rtsi_pkg::S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         rtsi_pkg::S_CHECK: begin
         end
         rtsi_pkg::S_GCD: begin
            cmd.gcd_step = !sts.gcd_done;
         end
         rtsi_pkg::S_NUM_LD: begin
            cmd.div_load = 1'b1;
            cmd.div_sel  = rtsi_pkg::DIV_NUM;
         end
         rtsi_pkg::S_NUM_DIV: begin
            cmd.div_step = !sts.div_done;
            cmd.num_save = sts.div_done;
         end
         rtsi_pkg::S_DEN_LD: begin
            cmd.div_load = 1'b1;
            cmd.div_sel  = rtsi_pkg::DIV_DEN;
         end
         rtsi_pkg::S_DEN_DIV: begin
            cmd.div_step = !sts.div_done;
            cmd.den_save = sts.div_done;
         end
         rtsi_pkg::S_SCL_LD: begin
            cmd.div_load = 1'b1;
            cmd.div_sel  = rtsi_pkg::DIV_SCL;
         end
         rtsi_pkg::S_SCL_DIV: begin
            cmd.div_step = !sts.div_done;
         end
         rtsi_pkg::S_MUL: begin
            cmd.mul = 1'b1;
         end
         rtsi_pkg::S_FIN: begin
            cmd.fin = 1'b1;
         end
         rtsi_pkg::S_DONE: begin
            rsp_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

[rtl/rtsi_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none

module rtsi_dpath (
   input  wire logic                                  clock,
   input  wire rtsi_pkg::cmd_type                     cmd,
   output rtsi_pkg::sts_type                          sts,
   input  wire logic signed [rtsi_pkg::WORD_BITS-1:0] req_frac_num,
   input  wire logic signed [rtsi_pkg::WORD_BITS-1:0] req_frac_den,
   input  wire logic signed [rtsi_pkg::WORD_BITS-1:0] req_scale_factor,
   output logic signed [rtsi_pkg::WORD_BITS-1:0]      rsp_scaled_value,
   output logic [1:0]                                 rsp_status
);

   localparam int W = rtsi_pkg::WORD_BITS;

   logic                           num_neg_ff;
   logic                           scl_neg_ff;
   logic                           bad_den_ff;
   logic [W-1:0]                   num_mag_ff;
   logic [W-1:0]                   den_ff;
   logic [W-1:0]                   scl_mag_ff;
   logic [W-1:0]                   a_ff;
   logic [W-1:0]                   b_ff;
   logic [rtsi_pkg::SHIFT_BITS-1:0] k_ff;
   logic [W-1:0]                   rnum_ff;
   logic [W-1:0]                   rden_ff;
   logic [W-1:0]                   rem_ff;
   logic [W-1:0]                   quo_ff;
   logic [W-1:0]                   dvs_ff;
   logic [rtsi_pkg::CNT_BITS-1:0]  cnt_ff;
   logic [2*W-1:0]                 prod_ff;
   logic signed [W-1:0]            value_ff;
   rtsi_pkg::status_type           status_ff;

   logic [W-1:0] gcd_val;
   logic [W:0]   trial;
   logic [W:0]   diff;
   logic         neg;
   logic         ovf;

   assign gcd_val = b_ff << k_ff;
   assign trial   = {rem_ff, quo_ff[W-1]};
   assign diff    = trial - {1'b0, dvs_ff};
   assign neg     = num_neg_ff ^ scl_neg_ff;
   assign ovf     = (|prod_ff[2*W-1:W])
                  | (neg ? (prod_ff[W-1] & (|prod_ff[W-2:0])) : prod_ff[W-1]);

   assign sts.bad_den  = bad_den_ff;
   assign sts.gcd_done = (a_ff == '0);
   assign sts.div_done = (cnt_ff == rtsi_pkg::CNT_BITS'(W));

   // input capture and binary gcd
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         num_neg_ff <= req_frac_num[W-1];
         num_mag_ff <= req_frac_num[W-1] ? (W'(0) - req_frac_num) : req_frac_num;
         scl_neg_ff <= req_scale_factor[W-1];
         scl_mag_ff <= req_scale_factor[W-1] ? (W'(0) - req_scale_factor)
                                             : req_scale_factor;
         den_ff     <= req_frac_den;
         bad_den_ff <= req_frac_den[W-1] | (req_frac_den == '0);
         a_ff       <= req_frac_num[W-1] ? (W'(0) - req_frac_num) : req_frac_num;
         b_ff       <= req_frac_den;
         k_ff       <= '0;
      end else if (cmd.gcd_step) begin
         priority if (!a_ff[0] && !b_ff[0]) begin
            a_ff <= a_ff >> 1;
            b_ff <= b_ff >> 1;
            k_ff <= k_ff + 1'b1;
         end else if (!a_ff[0]) begin
            a_ff <= a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_ff <= b_ff >> 1;
         end else if (a_ff >= b_ff) begin
            a_ff <= (a_ff - b_ff) >> 1;
         end else begin
            b_ff <= (b_ff - a_ff) >> 1;
         end
      end
   end

   // shared restoring divider, one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         rem_ff <= '0;
         cnt_ff <= '0;
         unique case (cmd.div_sel)
            rtsi_pkg::DIV_NUM: begin
               quo_ff <= num_mag_ff;
               dvs_ff <= gcd_val;
            end
            rtsi_pkg::DIV_DEN: begin
               quo_ff <= den_ff;
               dvs_ff <= gcd_val;
            end
            rtsi_pkg::DIV_SCL: begin
               quo_ff <= scl_mag_ff;
               dvs_ff <= rden_ff;
            end
            default: begin
               quo_ff <= scl_mag_ff;
               dvs_ff <= rden_ff;
            end
         endcase
      end else if (cmd.div_step) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (!diff[W]) begin
            rem_ff <= diff[W-1:0];
            quo_ff <= {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_ff <= trial[W-1:0];
            quo_ff <= {quo_ff[W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.num_save) rnum_ff <= quo_ff;
      if (cmd.den_save) rden_ff <= quo_ff;
      if (cmd.mul)      prod_ff <= {{W{1'b0}}, rnum_ff} * {{W{1'b0}}, quo_ff};
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.fin) begin
         priority if (bad_den_ff) begin
            status_ff <= rtsi_pkg::ST_BAD_DEN;
            value_ff  <= '0;
         end else if (rem_ff != '0) begin
            status_ff <= rtsi_pkg::ST_INEXACT;
            value_ff  <= '0;
         end else if (ovf) begin
            status_ff <= rtsi_pkg::ST_OVERFLOW;
            value_ff  <= '0;
         end else begin
            status_ff <= rtsi_pkg::ST_OK;
            value_ff  <= neg ? (W'(0) - prod_ff[W-1:0]) : prod_ff[W-1:0];
         end
      end
   end

   assign rsp_scaled_value = value_ff;
   assign rsp_status       = status_ff;

endmodule

`default_nettype wire

[rtl/rational_to_scaled_integer.sv]
// rational_to_scaled_integer
//
// Returns frac_num * scale_factor / frac_den exactly, or an error status.
// Input channel req_*: valid/ready; an item is taken when req_valid and
// req_ready are both high. req_ready is high only while the block is idle,
// so one item is in flight at a time.
// Result channel rsp_*: valid/ready; rsp_valid stays high with the result
// held until rsp_ready is seen, and the block takes no new item until then.
// A stalled receiver therefore stalls the input side.
// When the denominator is not positive, the controller goes from accept
// through the check and finish states to rsp_valid; otherwise it runs the
// binary gcd loop, then three passes through the single restoring divider
// (numerator / gcd, denominator / gcd, scale / reduced denominator), then
// the multiply and finish states. A new item is taken only after the result
// handshake and the return to idle.
// Reset (synchronous, active high) returns the controller to idle with no
// result pending; any item in flight is dropped.
`timescale 1ns / 1ps
`default_nettype none

module rational_to_scaled_integer (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic signed [rtsi_pkg::WORD_BITS-1:0] req_frac_num,
   input  wire logic signed [rtsi_pkg::WORD_BITS-1:0] req_frac_den,
   input  wire logic signed [rtsi_pkg::WORD_BITS-1:0] req_scale_factor,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed [rtsi_pkg::WORD_BITS-1:0]      rsp_scaled_value,
   output logic [1:0]                                 rsp_status
);

   rtsi_pkg::cmd_type cmd;
   rtsi_pkg::sts_type sts;

   rtsi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   rtsi_dpath u_dpath (
      .clock            (clock),
      .cmd              (cmd),
      .sts              (sts),
      .req_frac_num     (req_frac_num),
      .req_frac_den     (req_frac_den),
      .req_scale_factor (req_scale_factor),
      .rsp_scaled_value (rsp_scaled_value),
      .rsp_status       (rsp_status)
   );

endmodule

`default_nettype wire
